[hdl/tcsg_pkg.sv]
package tcsg_pkg;

   // texture geometry (square, power of two)
   localparam int TEX_SIZE = 64;
   localparam int TEX_BITS = $clog2(TEX_SIZE);
   // largest screen column height
   localparam int MAX_ROWS = 1024;
   localparam logic [10:0] MAX_H = 11'((MAX_ROWS > 2047) ? 2047 : MAX_ROWS);

   // step = (TEX_SIZE << 16) / height: quotient width and divider count
   localparam int QUO_W = 17 + TEX_BITS;
   localparam int CNT_W = $clog2(QUO_W);

   // shared multiplier operand widths
   localparam int MA_W   = 27;
   localparam int MB_W   = ((QUO_W > 18) ? QUO_W : 18) + 1;
   localparam int PROD_W = MA_W + MB_W;

   // item framing
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 96;

   localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd480;

   // action codes
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_ROW   = 1'b1;

   // pixel kinds
   localparam logic [1:0] KIND_CEILING = 2'd0;
   localparam logic [1:0] KIND_WALL    = 2'd1;
   localparam logic [1:0] KIND_FLOOR   = 2'd2;

   // register indexes
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd0;
   localparam logic [1:0] REG_CEILING_COLOR = 2'd1;
   localparam logic [1:0] REG_FLOOR_COLOR   = 2'd2;

   // column setup sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HIT,
      ST_FRAC,
      ST_DIV,
      ST_STEP,
      ST_MUL,
      ST_LOAD
   } state_type;

endpackage

[hdl/textured_column_span_generator_unit.sv]
// Textured column span generator for a raycaster.
// Input channel (req_): one item per tvalid/tready handshake. tuser = 0 starts a
// column with the ray's hit data in tdata; tuser = 1 asks for the next row.
// Result channel (rsp_): one pixel per row item while a column is active, tlast
// on the column's last row, tuser gives the pixel kind (ceiling, wall, floor).
// Config (csr_): APB-style, screen height at 0x0, ceiling color at 0x4, floor
// color at 0x8; pready is always high, reads return the register.
// Start item: the sequencer walks HIT, FRAC, DIV, STEP, MUL and LOAD, with the
// bit-per-cycle restoring divider computing the texture step in DIV plus
// two passes through the one shared multiplier (hit offset, start position).
// Ready is low during that sequence. A start item gives no result.
// Row item: one row per clock when the receiver keeps up.
// Results sit in an output register; while it is full and rsp_tready is low,
// req_tready is low and the pixel holds.
// Reset (synchronous, active high) returns the block to idle with no active
// column and the registers at their defaults (height 480, colors 0).
module textured_column_span_generator_unit (
   input  logic         clock,
   input  logic         reset,
   // input items
   input  logic         req_tvalid,
   output logic         req_tready,
   // [11:0] column, [12] side, [36:13] pos_x, [60:37] pos_y, [78:61] ray_dir_x,
   // [96:79] ray_dir_y, [122:97] perp_dist, [138:123] stripe_height,
   // [148:139] span_top, [159:149] span_bottom
   input  logic [159:0] req_tdata,
   // [0] action
   input  logic         req_tuser,
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [11:0] out_column, [21:12] out_row, [23:22] texture_id,
   // [35:24] texel_index, [67:36] fill_color, [93:68] wall_depth, [95:94] zero
   output logic [95:0]  rsp_tdata,
   // [1:0] pixel_kind
   output logic [1:0]   rsp_tuser,
   // column_done
   output logic         rsp_tlast,
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   tcsg_pkg::state_type state_ff, state_in;

   logic [10:0] screen_height_ff, screen_height_in;
   logic [31:0] ceiling_color_ff, ceiling_color_in;
   logic [31:0] floor_color_ff, floor_color_in;

   logic signed [tcsg_pkg::MA_W-1:0]   op_a_ff, op_a_in;
   logic signed [tcsg_pkg::MB_W-1:0]   op_b_ff, op_b_in;
   logic signed [tcsg_pkg::PROD_W-1:0] mul_ff;

   logic [15:0]                    pos_frac_ff, pos_frac_in;
   logic                           mirror_ff, mirror_in;
   logic [1:0]                     selected_texture_ff, selected_texture_in;
   logic [tcsg_pkg::TEX_BITS-1:0]  tex_column_ff, tex_column_in;
   logic [15:0]                    sh_ff, sh_in;
   logic [tcsg_pkg::CNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [15:0]                    rem_ff, rem_in;
   logic [tcsg_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [31:0]                    tex_step_ff, tex_step_in;
   logic [31:0]                    tex_position_ff, tex_position_in;
   logic [9:0]                     span_first_ff, span_first_in;
   logic [10:0]                    span_last_ff, span_last_in;
   logic [11:0]                    current_column_ff, current_column_in;
   logic [25:0]                    column_depth_ff, column_depth_in;
   logic [10:0]                    row_counter_ff, row_counter_in;
   logic                           column_active_ff, column_active_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff, rsp_last_in;

   // input field views
   logic               in_side;
   logic [23:0]        in_pos_x, in_pos_y;
   logic signed [17:0] in_dir_x, in_dir_y;
   logic [25:0]        in_perp;

   logic        req_fire, csr_write;
   logic [10:0] eff_h;

   // row path
   logic                          row_fire;
   logic [1:0]                    row_kind;
   logic [tcsg_pkg::TEX_BITS-1:0] tex_row;
   logic [11:0]                   row_texel;
   logic [31:0]                   row_fill;
   logic [1:0]                    row_tid;
   logic                          row_done;

   // setup path
   logic [15:0]                   frac;
   logic [tcsg_pkg::TEX_BITS-1:0] frac_col;
   logic [15:0]                   divisor;
   logic                          div_bit;
   logic [16:0]                   trial;
   logic signed [17:0]            base;

   assign in_side  = req_tdata[12];
   assign in_pos_x = req_tdata[36:13];
   assign in_pos_y = req_tdata[60:37];
   assign in_dir_x = $signed(req_tdata[78:61]);
   assign in_dir_y = $signed(req_tdata[96:79]);
   assign in_perp  = req_tdata[122:97];

   assign req_tready = (state_ff == tcsg_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // effective height, clamped to 1..MAX_ROWS
   always_comb begin
      priority if (screen_height_ff == 11'd0) begin
         eff_h = 11'd1;
      end else if (screen_height_ff > tcsg_pkg::MAX_H) begin
         eff_h = tcsg_pkg::MAX_H;
      end else begin
         eff_h = screen_height_ff;
      end
   end

   // pixel classification for the current row
   assign row_fire = req_fire && (req_tuser == tcsg_pkg::ACT_ROW) && column_active_ff;
   assign tex_row  = tex_position_ff[16 +: tcsg_pkg::TEX_BITS];
   assign row_done = ({1'b0, row_counter_ff} + 12'd1) >= {1'b0, eff_h};

   always_comb begin
      priority if (row_counter_ff >= span_last_ff) begin
         row_kind  = tcsg_pkg::KIND_FLOOR;
         row_fill  = floor_color_ff;
         row_tid   = 2'd0;
         row_texel = 12'd0;
      end else if (row_counter_ff < {1'b0, span_first_ff}) begin
         row_kind  = tcsg_pkg::KIND_CEILING;
         row_fill  = ceiling_color_ff;
         row_tid   = 2'd0;
         row_texel = 12'd0;
      end else begin
         row_kind  = tcsg_pkg::KIND_WALL;
         row_fill  = 32'd0;
         row_tid   = selected_texture_ff;
         row_texel = 12'({tex_row, tex_column_ff});
      end
   end

   // hit fraction and texture column from the hit product
   assign frac     = pos_frac_ff + mul_ff[31:16];
   assign frac_col = mirror_ff ? ~frac[15 -: tcsg_pkg::TEX_BITS]
                               : frac[15 -: tcsg_pkg::TEX_BITS];

   // restoring divider step; the dividend is a single one in its top bit
   assign divisor = (sh_ff == 16'd0) ? 16'd1 : sh_ff;
   assign div_bit = (div_cnt_ff == '0);
   assign trial   = {rem_ff, div_bit} - {1'b0, divisor};

   // start offset of the texture walk
   assign base = $signed(18'(span_first_ff) - 18'(eff_h >> 1) + 18'(sh_ff >> 1));

   // sequencer, register writes and row emission
   always_comb begin
      state_in            = state_ff;
      screen_height_in    = screen_height_ff;
      ceiling_color_in    = ceiling_color_ff;
      floor_color_in      = floor_color_ff;
      op_a_in             = op_a_ff;
      op_b_in             = op_b_ff;
      pos_frac_in         = pos_frac_ff;
      mirror_in           = mirror_ff;
      selected_texture_in = selected_texture_ff;
      tex_column_in       = tex_column_ff;
      sh_in               = sh_ff;
      div_cnt_in          = div_cnt_ff;
      rem_in              = rem_ff;
      quo_in              = quo_ff;
      tex_step_in         = tex_step_ff;
      tex_position_in     = tex_position_ff;
      span_first_in       = span_first_ff;
      span_last_in        = span_last_ff;
      current_column_in   = current_column_ff;
      column_depth_in     = column_depth_ff;
      row_counter_in      = row_counter_ff;
      column_active_in    = column_active_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_tready;
      rsp_data_in         = rsp_data_ff;
      rsp_kind_in         = rsp_kind_ff;
      rsp_last_in         = rsp_last_ff;

      if (csr_write) begin
         unique case (csr_paddr[3:2])
            tcsg_pkg::REG_SCREEN_HEIGHT: screen_height_in = csr_pwdata[10:0];
            tcsg_pkg::REG_CEILING_COLOR: ceiling_color_in = csr_pwdata;
            tcsg_pkg::REG_FLOOR_COLOR:   floor_color_in   = csr_pwdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         tcsg_pkg::ST_IDLE: begin
            if (req_fire && (req_tuser == tcsg_pkg::ACT_START)) begin
               // latch hit data, multiply distance by the ray component
               op_a_in           = tcsg_pkg::MA_W'(in_perp);
               if (in_side) begin
                  op_b_in             = tcsg_pkg::MB_W'(in_dir_x);
                  pos_frac_in         = in_pos_x[15:0];
                  mirror_in           = in_dir_y[17];
                  selected_texture_in = in_dir_y[17] ? 2'd0 : 2'd1;
               end else begin
                  op_b_in             = tcsg_pkg::MB_W'(in_dir_y);
                  pos_frac_in         = in_pos_y[15:0];
                  mirror_in           = !in_dir_x[17] && (in_dir_x != 18'sd0);
                  selected_texture_in = in_dir_x[17] ? 2'd2 : 2'd3;
               end
               current_column_in = req_tdata[11:0];
               column_depth_in   = in_perp;
               sh_in             = req_tdata[138:123];
               span_first_in     = req_tdata[148:139];
               span_last_in      = req_tdata[159:149];
               row_counter_in    = 11'd0;
               column_active_in  = 1'b0;
               state_in          = tcsg_pkg::ST_HIT;
            end else if (row_fire) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = row_kind;
               rsp_last_in    = row_done;
               rsp_data_in    = {2'b00, column_depth_ff, row_fill, row_texel, row_tid,
                                 row_counter_ff[9:0], current_column_ff};
               row_counter_in = row_counter_ff + 11'd1;
               if (row_kind == tcsg_pkg::KIND_WALL) begin
                  tex_position_in = tex_position_ff + tex_step_ff;
               end
               if (row_done) begin
                  column_active_in = 1'b0;
               end
            end
         end
         tcsg_pkg::ST_HIT: begin
            state_in = tcsg_pkg::ST_FRAC;
         end
         tcsg_pkg::ST_FRAC: begin
            tex_column_in = frac_col;
            div_cnt_in    = '0;
            rem_in        = 16'd0;
            quo_in        = '0;
            state_in      = tcsg_pkg::ST_DIV;
         end
         tcsg_pkg::ST_DIV: begin
            if (!trial[16]) begin
               rem_in = trial[15:0];
            end else begin
               rem_in = {rem_ff[14:0], div_bit};
            end
            quo_in     = {quo_ff[tcsg_pkg::QUO_W-2:0], !trial[16]};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == tcsg_pkg::CNT_W'(tcsg_pkg::QUO_W - 1)) begin
               state_in = tcsg_pkg::ST_STEP;
            end
         end
         tcsg_pkg::ST_STEP: begin
            tex_step_in = 32'(quo_ff);
            op_a_in     = tcsg_pkg::MA_W'(base);
            op_b_in     = tcsg_pkg::MB_W'(quo_ff);
            state_in    = tcsg_pkg::ST_MUL;
         end
         tcsg_pkg::ST_MUL: begin
            state_in = tcsg_pkg::ST_LOAD;
         end
         tcsg_pkg::ST_LOAD: begin
            tex_position_in  = mul_ff[31:0];
            column_active_in = 1'b1;
            state_in         = tcsg_pkg::ST_IDLE;
         end
         default: begin
            state_in = tcsg_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= tcsg_pkg::ST_IDLE;
         screen_height_ff    <= tcsg_pkg::SCREEN_HEIGHT_RST;
         ceiling_color_ff    <= 32'd0;
         floor_color_ff      <= 32'd0;
         row_counter_ff      <= 11'd0;
         tex_position_ff     <= 32'd0;
         tex_step_ff         <= 32'd0;
         tex_column_ff       <= '0;
         selected_texture_ff <= 2'd0;
         span_first_ff       <= 10'd0;
         span_last_ff        <= 11'd0;
         current_column_ff   <= 12'd0;
         column_depth_ff     <= 26'd0;
         column_active_ff    <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         screen_height_ff    <= screen_height_in;
         ceiling_color_ff    <= ceiling_color_in;
         floor_color_ff      <= floor_color_in;
         row_counter_ff      <= row_counter_in;
         tex_position_ff     <= tex_position_in;
         tex_step_ff         <= tex_step_in;
         tex_column_ff       <= tex_column_in;
         selected_texture_ff <= selected_texture_in;
         span_first_ff       <= span_first_in;
         span_last_ff        <= span_last_in;
         current_column_ff   <= current_column_in;
         column_depth_ff     <= column_depth_in;
         column_active_ff    <= column_active_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   // datapath and result payload
   always_ff @(posedge clock) begin
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      mul_ff      <= op_a_ff * op_b_ff;
      pos_frac_ff <= pos_frac_in;
      mirror_ff   <= mirror_in;
      sh_ff       <= sh_in;
      div_cnt_ff  <= div_cnt_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // register read-back
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[3:2])
         tcsg_pkg::REG_SCREEN_HEIGHT: csr_prdata = {21'd0, screen_height_ff};
         tcsg_pkg::REG_CEILING_COLOR: csr_prdata = ceiling_color_ff;
         tcsg_pkg::REG_FLOOR_COLOR:   csr_prdata = floor_color_ff;
         default:                     csr_prdata = 32'd0;
      endcase
   end

`ifndef SYNTH
   // a start item always occupies the sequencer for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == tcsg_pkg::ACT_START)) |=> !req_tready)
      else $error("ready high right after a start item");

   // the last row of a column ends the column
   assert property (@(posedge clock) disable iff (reset)
      (row_fire && row_done) |=> !column_active_ff)
      else $error("column still active after its last row");

   // wall pixels carry no fill, fill pixels carry no texel
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == tcsg_pkg::KIND_WALL)) |-> (rsp_tdata[67:36] == 32'd0))
      else $error("wall pixel with a fill color");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != tcsg_pkg::KIND_WALL))
         |-> (rsp_tdata[35:22] == 14'd0))
      else $error("fill pixel with texture data");
`endif

endmodule
